// ----- rtl/chms_pkg.sv -----
// Shared types and constants for the channel membership set.
package chms_pkg;

  localparam int SLOTS        = 16;
  localparam int NODE_BITS    = 8;
  localparam int CHANNEL_BITS = 16;
  localparam int IDX_W        = $clog2(SLOTS);

  localparam int MODE_W       = 2;
  localparam int NODE_W       = 8;
  localparam int CHANNEL_W    = 16;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_TEST   = 2'd3
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic add_first;
    logic write_idx;
    logic grow;
    logic idx_inc;
    logic idx_dec;
    logic kill;
    logic set_top_idx;
    logic set_empty;
    logic res_load;
    logic res_found;
    logic res_status;
  } chms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  empty;
    logic  idx_lt_top;
    logic  idx_eq_top;
    logic  idx_zero;
    logic  top_full;
    logic  live_idx;
    logic  match;
  } chms_sts_t;

endpackage

// ----- rtl/channel_membership_set.sv -----
// Top level of the channel membership set: a table of (node, channel) pairs.
// An operation on an empty set goes straight to the result; add walks past live slots
// to the first free slot below the high-water index, or else grows the top;
// test and remove scan the table slot by slot, and a remove of the top entry walks
// the index down to the next live slot.
// One item is in work at a time and a stalled result delays the next; reset empties the set.
module channel_membership_set (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [chms_pkg::IN_TDATA_W-1:0]  in_tdata,   // mode[1:0], node[9:2], channel[25:10]
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [chms_pkg::OUT_TDATA_W-1:0] out_tdata   // found[0], status[1]
);

  // The controller walks a scan index over the slot table, one slot per step,
  // and the datapath reports the live bit and a compare of the registered read data at that index.
  chms_pkg::chms_cmd_t cmd;
  chms_pkg::chms_sts_t sts;
  logic                res_found;
  logic                res_status;

  chms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Input fields are unpacked here; the datapath keeps the low NODE_BITS and
  // CHANNEL_BITS of them as the key.
  chms_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_tdata[1:0]),
    .in_node    (in_tdata[9:2]),
    .in_channel (in_tdata[25:10]),
    .res_found  (res_found),
    .res_status (res_status)
  );

  // The result register in the datapath holds the finished transaction while
  // the next input transaction is taken.
  assign out_tdata = {6'b0, res_status, res_found};

endmodule

// ----- rtl/chms_dp.sv -----
// Datapath: slot table, live bits, high-water index, scan index and result register.
module chms_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  chms_pkg::chms_cmd_t               cmd,
  output chms_pkg::chms_sts_t               sts,
  input  logic [chms_pkg::MODE_W-1:0]       in_mode,
  input  logic [chms_pkg::NODE_W-1:0]       in_node,
  input  logic [chms_pkg::CHANNEL_W-1:0]    in_channel,
  output logic                              res_found,
  output logic                              res_status
);

  logic [chms_pkg::NODE_BITS-1:0]    mem_node    [chms_pkg::SLOTS];
  logic [chms_pkg::CHANNEL_BITS-1:0] mem_channel [chms_pkg::SLOTS];

  logic [chms_pkg::SLOTS-1:0]        live_r;
  logic [chms_pkg::IDX_W-1:0]        top_r;
  logic                              empty_r;
  logic [chms_pkg::IDX_W-1:0]        idx_r;
  chms_pkg::mode_t                   mode_r;
  logic [chms_pkg::NODE_BITS-1:0]    key_node_r;
  logic [chms_pkg::CHANNEL_BITS-1:0] key_channel_r;
  logic [chms_pkg::NODE_BITS-1:0]    rd_node_r;
  logic [chms_pkg::CHANNEL_BITS-1:0] rd_channel_r;
  logic                              found_r;
  logic                              status_r;

  logic                              wr_en;
  logic [chms_pkg::IDX_W-1:0]        wr_addr;
  logic [chms_pkg::IDX_W-1:0]        top_inc;

  assign top_inc = chms_pkg::IDX_W'(top_r + 1'b1);
  assign wr_en   = cmd.add_first | cmd.write_idx | cmd.grow;

  always_comb begin
    priority if (cmd.add_first) begin
      wr_addr = '0;
    end else if (cmd.grow) begin
      wr_addr = top_inc;
    end else begin
      wr_addr = idx_r;
    end
  end

  // Slot table; read data is registered at the scan index every cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_node[wr_addr]    <= key_node_r;
      mem_channel[wr_addr] <= key_channel_r;
    end
    rd_node_r    <= mem_node[idx_r];
    rd_channel_r <= mem_channel[idx_r];
  end

  // Captured operation, scan index and result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r        <= chms_pkg::mode_t'(in_mode);
      key_node_r    <= in_node[chms_pkg::NODE_BITS-1:0];
      key_channel_r <= in_channel[chms_pkg::CHANNEL_BITS-1:0];
      idx_r         <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= chms_pkg::IDX_W'(idx_r + 1'b1);
    end else if (cmd.idx_dec) begin
      idx_r <= chms_pkg::IDX_W'(idx_r - 1'b1);
    end
    if (cmd.res_load) begin
      found_r  <= cmd.res_found;
      status_r <= cmd.res_status;
    end
  end

  // Set state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= '0;
      top_r   <= '0;
      empty_r <= 1'b1;
    end else begin
      if (cmd.clear) begin
        live_r  <= '0;
        top_r   <= '0;
        empty_r <= 1'b1;
      end else if (cmd.add_first) begin
        live_r[0] <= 1'b1;
        top_r     <= '0;
        empty_r   <= 1'b0;
      end else if (cmd.write_idx) begin
        live_r[idx_r] <= 1'b1;
      end else if (cmd.grow) begin
        live_r[top_inc] <= 1'b1;
        top_r           <= top_inc;
      end else if (cmd.kill) begin
        live_r[idx_r] <= 1'b0;
        if (cmd.set_empty) begin
          top_r   <= '0;
          empty_r <= 1'b1;
        end
      end else if (cmd.set_top_idx) begin
        top_r <= idx_r;
      end else if (cmd.set_empty) begin
        top_r   <= '0;
        empty_r <= 1'b1;
      end
    end
  end

  always_comb begin
    sts.mode       = mode_r;
    sts.empty      = empty_r;
    sts.idx_lt_top = (idx_r < top_r);
    sts.idx_eq_top = (idx_r == top_r);
    sts.idx_zero   = (idx_r == '0);
    sts.top_full   = (top_r == chms_pkg::IDX_W'(chms_pkg::SLOTS - 1));
    sts.live_idx   = live_r[idx_r];
    sts.match      = live_r[idx_r] && (rd_node_r == key_node_r) &&
                     (rd_channel_r == key_channel_r);
  end

  assign res_found  = found_r;
  assign res_status = status_r;

endmodule

// ----- rtl/chms_ctrl.sv -----
// Controller: sequences each operation over the slot table and owns the handshakes.
module chms_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  chms_pkg::chms_sts_t  sts,
  output chms_pkg::chms_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_FREE,
    S_SCAN,
    S_CMP,
    S_DOWN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   found_r, found_nxt;
  logic   status_r, status_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load   = 1'b1;
          found_nxt  = 1'b0;
          status_nxt = 1'b0;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.mode)
          chms_pkg::MODE_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_DONE;
          end
          chms_pkg::MODE_ADD: begin
            if (sts.empty) begin
              cmd.add_first = 1'b1;
              state_nxt     = S_DONE;
            end else begin
              state_nxt = S_FREE;
            end
          end
          chms_pkg::MODE_REMOVE, chms_pkg::MODE_TEST: begin
            state_nxt = sts.empty ? S_DONE : S_SCAN;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FREE: begin
        if (sts.idx_lt_top) begin
          if (!sts.live_idx) begin
            cmd.write_idx = 1'b1;
            state_nxt     = S_DONE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end else if (sts.top_full) begin
          status_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.grow  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.match) begin
          if (sts.mode == chms_pkg::MODE_TEST) begin
            found_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            cmd.kill = 1'b1;
            if (sts.idx_eq_top && sts.idx_zero) begin
              cmd.set_empty = 1'b1;
              state_nxt     = S_DONE;
            end else if (sts.idx_eq_top) begin
              cmd.idx_dec = 1'b1;
              state_nxt   = S_DOWN;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end else if (sts.idx_eq_top) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_DOWN: begin
        if (sts.live_idx) begin
          cmd.set_top_idx = 1'b1;
          state_nxt       = S_DONE;
        end else if (sts.idx_zero) begin
          cmd.set_empty = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.idx_dec = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.res_load   = 1'b1;
          cmd.res_found  = found_r;
          cmd.res_status = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      status_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      found_r  <= found_nxt;
      status_r <= status_nxt;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/chms_checker.sv -----
// Port-level checks for the channel membership set, bound to the top level.
module chms_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [chms_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Only one item is in work: after a transaction is taken the input stalls.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // Found and full status never come together, and the padding bits stay zero.
  a_result_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]) && (out_tdata[7:2] == 6'b0))
    else $error("malformed result");

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind channel_membership_set chms_checker u_chms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- sim/channel_membership_set_test.sv -----
// Self-checking stream testbench for the channel membership set.
module channel_membership_set_test;

  localparam int RANDOM_ITEMS = 1600;
  localparam int SEGMENT_LEN  = 100;
  localparam int POOL_SIZE    = 12;
  localparam int DRAIN_CYCLES = 3 * chms_pkg::SLOTS + 10;

  // Receiver stall styles.
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_MOSTLY = 2;
  localparam int RX_SLOW   = 3;

  typedef struct packed {
    logic found;
    logic status;
  } set_reply_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [chms_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [chms_pkg::OUT_TDATA_W-1:0] out_tdata;

  channel_membership_set i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the pair table.
  logic                           shadow_live    [chms_pkg::SLOTS];
  logic [chms_pkg::NODE_W-1:0]    shadow_node    [chms_pkg::SLOTS];
  logic [chms_pkg::CHANNEL_W-1:0] shadow_channel [chms_pkg::SLOTS];
  int                             shadow_top   = 0;
  logic                           shadow_empty = 1'b1;

  set_reply_t pending_results[$];
  int         mismatch_count = 0;
  int         replies_seen   = 0;
  int         full_refusals  = 0;
  int         hits_seen      = 0;
  int         ops_sent[4]    = '{0, 0, 0, 0};
  int         burst_left     = 0;

  initial begin
    for (int i = 0; i < chms_pkg::SLOTS; i++) shadow_live[i] = 1'b0;
  end

  // Applies one transaction to the shadow table and returns the reply it should produce.
  function automatic set_reply_t apply_set_op(chms_pkg::mode_t m,
                                              logic [chms_pkg::NODE_W-1:0] n,
                                              logic [chms_pkg::CHANNEL_W-1:0] c);
    set_reply_t r;
    int hit;
    int nxt;
    r = '0;
    hit = -1;
    nxt = -1;
    case (m)
      chms_pkg::MODE_CLEAR: begin
        for (int i = 0; i < chms_pkg::SLOTS; i++) shadow_live[i] = 1'b0;
        shadow_top   = 0;
        shadow_empty = 1'b1;
      end
      chms_pkg::MODE_ADD: begin
        if (shadow_empty) begin
          shadow_empty      = 1'b0;
          shadow_top        = 0;
          hit               = 0;
        end else begin
          // Lowest free slot below the high-water index wins.
          for (int i = 0; i < shadow_top; i++)
            if (hit < 0 && !shadow_live[i]) hit = i;
          if (hit < 0) begin
            if (shadow_top >= chms_pkg::SLOTS - 1) begin
              r.status = 1'b1;
            end else begin
              shadow_top = shadow_top + 1;
              hit        = shadow_top;
            end
          end
        end
        if (hit >= 0) begin
          shadow_live[hit]    = 1'b1;
          shadow_node[hit]    = n;
          shadow_channel[hit] = c;
        end
      end
      chms_pkg::MODE_REMOVE: begin
        if (!shadow_empty) begin
          for (int i = 0; i <= shadow_top; i++)
            if (hit < 0 && shadow_live[i] && shadow_node[i] == n && shadow_channel[i] == c)
              hit = i;
          if (hit >= 0) begin
            shadow_live[hit] = 1'b0;
            if (hit == shadow_top) begin
              // Walk down to the next live entry, or the set becomes empty.
              for (int j = hit - 1; j >= 0; j--)
                if (nxt < 0 && shadow_live[j]) nxt = j;
              if (nxt >= 0) begin
                shadow_top = nxt;
              end else begin
                shadow_top   = 0;
                shadow_empty = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        if (!shadow_empty)
          for (int i = 0; i <= shadow_top; i++)
            if (shadow_live[i] && shadow_node[i] == n && shadow_channel[i] == c)
              r.found = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Sends one transaction; the sender runs in bursts with random gaps between them.
  task automatic send_item(input chms_pkg::mode_t m, input logic [chms_pkg::NODE_W-1:0] n,
                           input logic [chms_pkg::CHANNEL_W-1:0] c);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(20, 60);
      end else begin
        gap        = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 8);
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(chms_pkg::IN_TDATA_W - chms_pkg::MODE_W - chms_pkg::NODE_W -
                    chms_pkg::CHANNEL_W){1'b0}}, c, n, m};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_set_op(m, n, c));
    ops_sent[m] = ops_sent[m] + 1;
    burst_left  = burst_left - 1;
  endtask

  // Receiver: switches between randomly chosen stall styles.
  int         rx_style = RX_OPEN;
  int         rx_left  = 0;
  logic [2:0] rx_phase = '0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style <= $urandom_range(RX_OPEN, RX_SLOW);
      rx_left  <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= rx_phase + 3'd1;
    case (rx_style)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
      default:   out_tready <= (rx_phase == 3'd0);
    endcase
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    set_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      replies_seen <= replies_seen + 1;
      if (pending_results.size() == 0) begin
        $error("result arrived with no expectation pending: tdata %h", out_tdata);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = pending_results.pop_front();
        if (want.found) hits_seen <= hits_seen + 1;
        if (want.status) full_refusals <= full_refusals + 1;
        if (out_tdata[0] !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_tdata[0]);
          mismatch_count = mismatch_count + 1;
        end
        if (out_tdata[1] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tdata[1]);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  task automatic test_empty_set();
    send_item(chms_pkg::MODE_TEST, 8'h00, 16'h0000);
    send_item(chms_pkg::MODE_REMOVE, 8'hFF, 16'hFFFF);
    send_item(chms_pkg::MODE_CLEAR, 8'h5A, 16'hA5A5);
  endtask

  // Fills every slot with the field extremes at both ends, then adds past full
  // and removes the top entry so the index walks down.
  task automatic test_full_table();
    for (int i = 0; i < chms_pkg::SLOTS; i++) begin
      if (i == chms_pkg::SLOTS - 1)
        send_item(chms_pkg::MODE_ADD, 8'hFF, 16'hFFFF);
      else
        send_item(chms_pkg::MODE_ADD, chms_pkg::NODE_W'(i * 17),
                  chms_pkg::CHANNEL_W'(i * 4099));
    end
    send_item(chms_pkg::MODE_ADD, 8'h42, 16'h1234);
    send_item(chms_pkg::MODE_REMOVE, 8'hFF, 16'hFFFF);
    send_item(chms_pkg::MODE_TEST, 8'hFF, 16'hFFFF);
    send_item(chms_pkg::MODE_CLEAR, 8'h00, 16'h0000);
  endtask

  // Add keeps duplicates; removing one copy leaves the other visible.
  task automatic test_duplicates();
    send_item(chms_pkg::MODE_ADD, 8'h07, 16'h0007);
    send_item(chms_pkg::MODE_ADD, 8'h07, 16'h0007);
    send_item(chms_pkg::MODE_REMOVE, 8'h07, 16'h0007);
    send_item(chms_pkg::MODE_TEST, 8'h07, 16'h0007);
  endtask

  // Mostly operations on a small pool of pairs, so that adds, removes and tests
  // hit each other; a share of full-range pairs keeps every data bit moving.
  task automatic test_random_traffic();
    logic [chms_pkg::NODE_W-1:0]    pool_node    [POOL_SIZE];
    logic [chms_pkg::CHANNEL_W-1:0] pool_channel [POOL_SIZE];
    int                             roll;
    int                             grow_bias;
    int                             pick;
    chms_pkg::mode_t                m;
    logic [chms_pkg::NODE_W-1:0]    n;
    logic [chms_pkg::CHANNEL_W-1:0] c;
    grow_bias = 0;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % SEGMENT_LEN == 0) begin
        for (int p = 0; p < POOL_SIZE; p++) begin
          pool_node[p]    = chms_pkg::NODE_W'($urandom);
          pool_channel[p] = chms_pkg::CHANNEL_W'($urandom);
        end
        grow_bias = $urandom_range(0, 1);
      end
      roll = $urandom_range(0, 99);
      if (roll < 4)
        m = chms_pkg::MODE_CLEAR;
      else if (roll < (grow_bias != 0 ? 60 : 35))
        m = chms_pkg::MODE_ADD;
      else if (roll < 75)
        m = chms_pkg::MODE_REMOVE;
      else
        m = chms_pkg::MODE_TEST;
      if ($urandom_range(0, 9) < 8) begin
        pick = $urandom_range(0, POOL_SIZE - 1);
        n    = pool_node[pick];
        c    = pool_channel[pick];
      end else begin
        n = chms_pkg::NODE_W'($urandom);
        c = chms_pkg::CHANNEL_W'($urandom);
      end
      send_item(m, n, c);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_set();
    test_full_table();
    test_duplicates();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d clears, %0d adds, %0d removes, %0d tests; %0d results checked.",
             ops_sent[chms_pkg::MODE_CLEAR], ops_sent[chms_pkg::MODE_ADD],
             ops_sent[chms_pkg::MODE_REMOVE], ops_sent[chms_pkg::MODE_TEST], replies_seen);
    $display("Membership hits: %0d, adds refused on a full table: %0d.",
             hits_seen, full_refusals);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/chms_pkg.sv
rtl/chms_dp.sv
rtl/chms_ctrl.sv
rtl/channel_membership_set.sv
rtl/chms_checker.sv
sim/channel_membership_set_test.sv
